// File: rtl/core/sm3_pkg.sv
// SM3 engine package: payload structs, constants and round helper functions.
// No dependencies; used by every module of the SM3 engine.
`timescale 1ns / 1ps
`default_nettype none
package sm3_pkg;

  typedef struct packed {
    logic [31:0] message_word;
    logic [2:0]  valid_bytes;
    logic        end_of_message;
  } sm3_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  digest_index;
    logic        digest_last;
  } sm3_out_t;

  // Word handed from the front part to the back part.
  // last_blk marks the final word of the padded message.
  typedef struct packed {
    logic [31:0] word;
    logic        last_blk;
  } sm3_bw_t;

  localparam logic [31:0] T_LOW  = 32'h79cc4519;
  localparam logic [31:0] T_HIGH = 32'h7a879d8a;
  localparam logic [31:0] PAD_ONE_BIT = 32'h80000000;
  localparam logic [255:0] SM3_IV = {
    32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
    32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e};

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic logic [31:0] perm0(input logic [31:0] x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic logic [31:0] perm1(input logic [31:0] x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/sm3_front.sv
// SM3 front part: counts message bits and turns input words into padded block words.
// Depends on sm3_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sm3_front
  import sm3_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_push,
  output logic         in_full,
  input  wire sm3_in_t in_data,
  output logic         bw_valid,
  input  wire logic    bw_ready,
  output sm3_bw_t      bw_data
);

  localparam logic [1:0] ST_DATA = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_LENH = 2'd2;
  localparam logic [1:0] ST_LENL = 2'd3;

  logic [1:0]  state_r, state_nxt;
  logic [63:0] len_r, len_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic        pad_one_r, pad_one_nxt;
  logic [2:0]  vb;
  logic [31:0] mask;
  logic [31:0] tail_word;
  logic        fire;

  // Clamp valid byte count and build the tail word, with its marker bit when fewer than four bytes are valid.
  always_comb begin
    vb = (in_data.valid_bytes > 3'd4) ? 3'd4 : in_data.valid_bytes;
    unique case (vb)
      3'd0:    mask = 32'h00000000;
      3'd1:    mask = 32'hff000000;
      3'd2:    mask = 32'hffff0000;
      3'd3:    mask = 32'hffffff00;
      default: mask = 32'hffffffff;
    endcase
    unique case (vb)
      3'd0:    tail_word = 32'h80000000;
      3'd1:    tail_word = (in_data.message_word & mask) | 32'h00800000;
      3'd2:    tail_word = (in_data.message_word & mask) | 32'h00008000;
      3'd3:    tail_word = (in_data.message_word & mask) | 32'h00000080;
      default: tail_word = in_data.message_word;
    endcase
  end

  // One word leaves per transfer; padding words are generated without input.
  always_comb begin
    state_nxt   = state_r;
    len_nxt     = len_r;
    pos_nxt     = pos_r;
    pad_one_nxt = pad_one_r;
    in_full     = 1'b1;
    bw_valid    = 1'b1;
    bw_data.last_blk = 1'b0;
    bw_data.word     = 32'h0;
    unique case (state_r)
      ST_DATA: begin
        in_full      = !bw_ready;
        bw_valid     = in_push;
        bw_data.word = in_data.end_of_message ? tail_word : in_data.message_word;
      end
      ST_ZERO: begin
        bw_data.word = pad_one_r ? PAD_ONE_BIT : 32'h0;
      end
      ST_LENH: bw_data.word = len_r[63:32];
      default: begin
        bw_data.word     = len_r[31:0];
        bw_data.last_blk = 1'b1;
      end
    endcase
    fire = bw_valid && bw_ready;
    if (fire) begin
      pos_nxt = pos_r + 4'd1;
      unique case (state_r)
        ST_DATA: begin
          if (!in_data.end_of_message) begin
            len_nxt = len_r + 64'd32;
          end else begin
            len_nxt     = len_r + {58'd0, vb, 3'd0};
            pad_one_nxt = (vb == 3'd4);
            state_nxt   = (vb != 3'd4 && pos_r == 4'd13) ? ST_LENH : ST_ZERO;
          end
        end
        ST_ZERO: begin
          pad_one_nxt = 1'b0;
          if (pos_r == 4'd13) state_nxt = ST_LENH;
        end
        ST_LENH: state_nxt = ST_LENL;
        default: begin
          state_nxt = ST_DATA;
          len_nxt   = 64'd0;
          pos_nxt   = 4'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_DATA;
      len_r     <= 64'd0;
      pos_r     <= 4'd0;
      pad_one_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      len_r     <= len_nxt;
      pos_r     <= pos_nxt;
      pad_one_r <= pad_one_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/sm3_fifo.sv
// Two-entry word queue between the SM3 front and back parts.
// Depends on sm3_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sm3_fifo
  import sm3_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    wr_valid,
  output logic         wr_ready,
  input  wire sm3_bw_t wr_data,
  output logic         rd_valid,
  input  wire logic    rd_ready,
  output sm3_bw_t      rd_data
);

  sm3_bw_t    mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr, rd;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  // Storage is payload only.
  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= !wp_r;
      if (rd) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/sm3_back.sv
// SM3 back part: block buffer, message expansion window, 64 rounds, digest output.
// Depends on sm3_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sm3_back
  import sm3_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    bw_valid,
  output logic         bw_ready,
  input  wire sm3_bw_t bw_data,
  output logic         out_empty,
  input  wire logic    out_pop,
  output sm3_out_t     out_data
);

  localparam logic [1:0] ST_LOAD  = 2'd0;
  localparam logic [1:0] ST_ROUND = 2'd1;
  localparam logic [1:0] ST_FOLD  = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]   state_r, state_nxt;
  logic [3:0]   pos_r;
  logic [5:0]   rnd_r;
  logic [2:0]   oidx_r;
  logic         fin_r;
  logic [31:0]  w_r [16];
  logic [31:0]  r_r [8];
  logic [255:0] cv_r;
  logic [31:0]  w_new, a12, ss1, ss2, ff, gg, tt1, tt2, tj;

  // Next expanded word and one compression round.
  always_comb begin
    w_new = perm1(w_r[0] ^ w_r[7] ^ rotl(w_r[13], 5'd15)) ^ rotl(w_r[3], 5'd7) ^ w_r[10];
    tj    = rotl((rnd_r < 6'd16) ? T_LOW : T_HIGH, rnd_r[4:0]);
    a12   = rotl(r_r[0], 5'd12);
    ss1   = rotl(a12 + r_r[4] + tj, 5'd7);
    ss2   = ss1 ^ a12;
    if (rnd_r < 6'd16) begin
      ff = r_r[0] ^ r_r[1] ^ r_r[2];
      gg = r_r[4] ^ r_r[5] ^ r_r[6];
    end else begin
      ff = (r_r[0] & r_r[1]) | (r_r[0] & r_r[2]) | (r_r[1] & r_r[2]);
      gg = (r_r[4] & r_r[5]) | (~r_r[4] & r_r[6]);
    end
    tt1 = ff + r_r[3] + ss2 + (w_r[0] ^ w_r[4]);
    tt2 = gg + r_r[7] + ss1 + w_r[0];
  end

  assign bw_ready  = (state_r == ST_LOAD);
  assign out_empty = (state_r != ST_EMIT);
  assign out_data.digest_word  = cv_r[255 - 32*oidx_r -: 32];
  assign out_data.digest_index = oidx_r;
  assign out_data.digest_last  = (oidx_r == 3'd7);

  // Sequencer: load 16 words, 64 rounds, fold, then optionally emit.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD:  if (bw_valid && pos_r == 4'd15) state_nxt = ST_ROUND;
      ST_ROUND: if (rnd_r == 6'd63) state_nxt = ST_FOLD;
      ST_FOLD:  state_nxt = fin_r ? ST_EMIT : ST_LOAD;
      default:  if (out_pop && oidx_r == 3'd7) state_nxt = ST_LOAD;
    endcase
  end

  // Word window shifts in on load and slides during the rounds.
  always_ff @(posedge clk) begin
    if ((state_r == ST_LOAD && bw_valid) || state_r == ST_ROUND) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= (state_r == ST_LOAD) ? bw_data.word : w_new;
    end
    if (state_r == ST_LOAD) begin
      for (int i = 0; i < 8; i++) r_r[i] <= cv_r[255 - 32*i -: 32];
    end else if (state_r == ST_ROUND) begin
      r_r[0] <= tt1;
      r_r[1] <= r_r[0];
      r_r[2] <= rotl(r_r[1], 5'd9);
      r_r[3] <= r_r[2];
      r_r[4] <= perm0(tt2);
      r_r[5] <= r_r[4];
      r_r[6] <= rotl(r_r[5], 5'd19);
      r_r[7] <= r_r[6];
    end
  end

  // Control state and chaining value.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      pos_r   <= 4'd0;
      rnd_r   <= 6'd0;
      oidx_r  <= 3'd0;
      fin_r   <= 1'b0;
      cv_r    <= SM3_IV;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_LOAD && bw_valid) begin
        pos_r <= pos_r + 4'd1;
        fin_r <= bw_data.last_blk;
      end
      if (state_r == ST_ROUND) rnd_r <= rnd_r + 6'd1;
      if (state_r == ST_FOLD) begin
        for (int i = 0; i < 8; i++) cv_r[255 - 32*i -: 32] <= cv_r[255 - 32*i -: 32] ^ r_r[i];
      end
      if (state_r == ST_EMIT && out_pop) begin
        oidx_r <= oidx_r + 3'd1;
        if (oidx_r == 3'd7) cv_r <= SM3_IV;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/sm3_hash_engine.sv
// SM3 hash engine top level: front padder, word queue and compression back part.
// Each block is loaded as 16 words, then goes through 64 rounds and a fold in the
// single shared round unit; the back part takes no new words during rounds and fold.
// After the final word come padding and the last block load, the rounds and fold,
// then eight digest transfers. Synchronous active-low reset restores the IV, empties
// the queue and zeroes the length count.
`timescale 1ns / 1ps
`default_nettype none
module sm3_hash_engine
  import sm3_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_push,
  output logic          in_full,
  input  wire sm3_in_t  in_data,
  output logic          out_empty,
  input  wire logic     out_pop,
  output sm3_out_t      out_data
);

  logic    f_valid, f_ready, b_valid, b_ready;
  sm3_bw_t f_data, b_data;

  sm3_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_data,
    .bw_valid(f_valid), .bw_ready(f_ready), .bw_data(f_data));

  sm3_fifo u_fifo (
    .clk, .rst_n,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_data));

  sm3_back u_back (
    .clk, .rst_n,
    .bw_valid(b_valid), .bw_ready(b_ready), .bw_data(b_data),
    .out_empty, .out_pop, .out_data);

endmodule
`default_nettype wire
